>>> rtl/sli_pkg.sv
// Shared types and constants for the sorted list intersection unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sli_pkg;

  localparam int unsigned ValueW = 24;
  localparam int unsigned DefaultListDepth = 512;

  // Element codes carried in the op field of an input request.
  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_elem;    // store a first-list element
    logic load_item;  // latch a second-list element
    logic rd_en;      // read the stored list
    logic rd_next;    // read address is pointer plus one
    logic ptr_inc;    // advance the read pointer
    logic emit;       // load the output register
    logic emit_hit;   // the emitted result is a match
    logic clear;      // drop the stored list and rewind the pointer
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt;        // pointer in range and stored value below the item
    logic eq;        // pointer in range and stored value equals the item
    logic more;      // pointer plus one is still inside the stored list
    logic last;      // latched item is the last of the second list
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

>>> rtl/sli_if.sv
// Valid/ready channel interfaces for the input and result requests.
// Depends on sli_pkg for the value width.
`default_nettype none

interface sli_in_if;
  import sli_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ValueW-1:0] item_value;
  logic              final_item;

  modport source (output valid, output op, output item_value, output final_item,
                  input ready);
  modport sink (input valid, input op, input item_value, input final_item,
                output ready);
endinterface

interface sli_out_if;
  import sli_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] match_value;
  logic              is_match;
  logic              list_done;

  modport source (output valid, output match_value, output is_match, output list_done,
                  input ready);
  modport sink (input valid, input match_value, input is_match, input list_done,
                output ready);
endinterface

`default_nettype wire

>>> rtl/sli_ctrl.sv
// Controller state machine: sequences store, compare and result requests.
// Depends on sli_pkg for the command and status structs.
`default_nettype none

module sli_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_op_i,
  output logic                  in_ready_o,
  input  wire sli_pkg::status_t status_i,
  output sli_pkg::cmd_t         cmd_o
);
  import sli_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCmp  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   hit_q, hit_d;
  logic   accept;
  logic   hit_now;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign hit_now    = status_i.eq;

  always_comb begin
    state_d = state_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_op_i == OpFirst) begin
            cmd_o.wr_elem = 1'b1;
          end else begin
            cmd_o.load_item = 1'b1;
            cmd_o.rd_en     = 1'b1;
            state_d         = StCmp;
          end
        end
      end
      StCmp: begin
        if (status_i.lt) begin
          cmd_o.ptr_inc = 1'b1;
          if (status_i.more) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_next = 1'b1;
          end else if (status_i.last) begin
            // Ran off the end of the stored list: report the end marker only.
            if (status_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.clear = 1'b1;
              state_d     = StIdle;
            end else begin
              hit_d   = 1'b0;
              state_d = StEmit;
            end
          end else begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.ptr_inc = hit_now;
          if (hit_now || status_i.last) begin
            if (status_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_hit = hit_now;
              cmd_o.clear    = status_i.last;
              state_d        = StIdle;
            end else begin
              hit_d   = hit_now;
              state_d = StEmit;
            end
          end else begin
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_hit = hit_q;
          cmd_o.clear    = status_i.last;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sli_dp.sv
// Datapath: first-list memory, count and read pointer, compare, result register.
// Depends on sli_pkg for the value width and the command and status structs.
`default_nettype none

module sli_dp #(
  parameter int unsigned LIST_DEPTH = sli_pkg::DefaultListDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [sli_pkg::ValueW-1:0] item_value_i,
  input  wire logic                       final_item_i,
  input  wire sli_pkg::cmd_t              cmd_i,
  output sli_pkg::status_t                status_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [sli_pkg::ValueW-1:0]      match_value_o,
  output logic                            is_match_o,
  output logic                            list_done_o
);
  import sli_pkg::*;

  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(LIST_DEPTH);

  logic [ValueW-1:0] store_q [LIST_DEPTH];
  logic [ValueW-1:0] rdata_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW:0]     ptr_plus1;
  logic [AddrW-1:0]  rd_addr;
  logic              cnt_full;
  logic              wr_en;
  logic              in_range;
  logic [ValueW-1:0] item_q;
  logic              last_q;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] match_value_q;
  logic              is_match_q;
  logic              list_done_q;
  logic              out_free;

  assign ptr_plus1 = {1'b0, ptr_q} + (CntW+1)'(1);
  assign cnt_full  = (cnt_q == CntW'(LIST_DEPTH));
  assign wr_en     = cmd_i.wr_elem && !cnt_full;
  assign rd_addr   = cmd_i.rd_next ? ptr_plus1[AddrW-1:0] : ptr_q[AddrW-1:0];
  assign in_range  = (ptr_q < cnt_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.lt       = in_range && (rdata_q < item_q);
  assign status_o.eq       = in_range && (rdata_q == item_q);
  assign status_o.more     = (ptr_plus1 < {1'b0, cnt_q});
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;

  // Entries at or above the count are never compared, so the store needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q[AddrW-1:0]] <= item_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_value_i;
      last_q <= final_item_i;
    end
    if (cmd_i.emit) begin
      match_value_q <= cmd_i.emit_hit ? item_q : '0;
      is_match_q    <= cmd_i.emit_hit;
      list_done_q   <= last_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    if (wr_en) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.ptr_inc) begin
      ptr_d = ptr_plus1[CntW-1:0];
    end
    if (cmd_i.clear) begin
      cnt_d = '0;
      ptr_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_value_o = match_value_q;
  assign is_match_o    = is_match_q;
  assign list_done_o   = list_done_q;

endmodule

`default_nettype wire

>>> rtl/sorted_list_intersection_unit.sv
// Top level of the sorted list intersection unit: controller plus datapath.
// Depends on sli_pkg, sli_if, sli_ctrl and sli_dp.
//
//   Channel | Direction | Payload                              | Accepted when
//   req_i   | in        | op, item_value, final_item           | valid && ready
//   res_o   | out       | match_value, is_match, list_done     | valid && ready
//
// Storing a first-list element does not hold off the next request. A second-list
// element is latched with a read of the stored entry at the pointer; the controller
// then steps the read pointer past each stored element below it, since the stored
// list is read one entry per cycle through a single registered memory port.
// A result waits in the output register while the next request is taken; only a
// second result finding that register still full holds the controller.
// Reset clears the count, pointer and handshakes; the memory itself is not cleared.
`default_nettype none

module sorted_list_intersection_unit #(
  parameter int unsigned LIST_DEPTH = sli_pkg::DefaultListDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sli_in_if.sink   req_i,
  sli_out_if.source res_o
);
  import sli_pkg::*;

  cmd_t    cmd;
  status_t status;

  sli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.op),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sli_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_value_i  (req_i.item_value),
    .final_item_i  (req_i.final_item),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .match_value_o (res_o.match_value),
    .is_match_o    (res_o.is_match),
    .list_done_o   (res_o.list_done)
  );

endmodule

`default_nettype wire

>>> rtl/sli_checker.sv
// Port-level checks for the sorted list intersection unit, bound to the top level.
// Depends on sli_pkg for the value width.
`default_nettype none

module sli_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_op_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [sli_pkg::ValueW-1:0] match_value_i,
  input wire logic                       is_match_i,
  input wire logic                       list_done_i
);
  import sli_pkg::*;

  // A pending result request stays up until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before it was taken");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(match_value_i) && $stable(is_match_i) && $stable(list_done_i))
    else $error("stalled result payload changed");

  // A non-match carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_match_i |-> match_value_i == '0)
    else $error("non-match result carries a nonzero value");

  // Accepting a second-list element always moves the controller out of idle to compare.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OpSecond |=> !in_ready_i)
    else $error("ready after a second-list element without a compare cycle");

  // Storing a first-list element never holds off the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OpFirst |=> in_ready_i)
    else $error("ready dropped after a first-list element");

endmodule

bind sorted_list_intersection_unit sli_checker u_sli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_op_i       (req_i.op),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .match_value_i (res_o.match_value),
  .is_match_i    (res_o.is_match),
  .list_done_i   (res_o.list_done)
);

`default_nettype wire
